// ===== hdl/slr_shift_reduce_parser_unit_macros.svh =====
// Assertion macros used by the parser datapath.
`ifndef SLR_SHIFT_REDUCE_PARSER_UNIT_MACROS_SVH
`define SLR_SHIFT_REDUCE_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/slr_pkg.sv =====
package slr_pkg;

  // Default sizes.
  localparam int DEF_STATE_COUNT     = 256;
  localparam int DEF_SYMBOL_COUNT    = 128;
  localparam int DEF_RULE_COUNT      = 256;
  localparam int DEF_STACK_DEPTH     = 256;
  localparam int DEF_REDUCE_LIMIT    = 63;
  localparam int DEF_MAX_RULE_LENGTH = 15;

  // Input operation codes.
  localparam logic [2:0] OP_LOAD_TRANS  = 3'd0;
  localparam logic [2:0] OP_LOAD_REDUCE = 3'd1;
  localparam logic [2:0] OP_LOAD_RULE   = 3'd2;
  localparam logic [2:0] OP_TOKEN       = 3'd3;
  localparam logic [2:0] OP_END         = 3'd4;
  localparam logic [2:0] OP_RESTART     = 3'd5;
  localparam logic [2:0] OP_UNUSED_6    = 3'd6;
  localparam logic [2:0] OP_UNUSED_7    = 3'd7;

  // Result kinds.
  localparam logic [2:0] KIND_REDUCE    = 3'd0;
  localparam logic [2:0] KIND_SHIFT     = 3'd1;
  localparam logic [2:0] KIND_SYNTAX    = 3'd2;
  localparam logic [2:0] KIND_FINAL     = 3'd3;
  localparam logic [2:0] KIND_CAPACITY  = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED_RD,
    ST_RED_CHK,
    ST_RULE_RD,
    ST_RULE_CHK,
    ST_POP_RD,
    ST_GOTO_RD,
    ST_GOTO_CHK
  } ctrl_state_t;

  // Datapath actions.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR_STEP,
    ACT_LOAD,
    ACT_RESTART,
    ACT_START_TOKEN,
    ACT_START_END,
    ACT_TAKE_RULE,
    ACT_POP,
    ACT_PUSH_GOTO,
    ACT_SHIFT,
    ACT_ERR_SYNTAX,
    ACT_ERR_LIMIT,
    ACT_ERR_FULL,
    ACT_ERR_RULE
  } dp_act_t;

  typedef struct packed {
    dp_act_t act;
    logic    goto_lk;
  } dp_cmd_t;

  typedef struct packed {
    logic failed;
    logic clr_done;
    logic out_free;
    logic red_hit;
    logic red_limit;
    logic trans_hit;
    logic stack_full;
    logic rule_bad;
    logic is_end;
  } dp_status_t;

endpackage

// ===== hdl/slr_ram.sv =====
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/slr_ctrl.sv =====
module slr_ctrl
  import slr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && !sts.failed) begin
          if (in_op == OP_TOKEN) state_nxt = ST_RED_RD;
          else if (in_op == OP_END) state_nxt = ST_RULE_RD;
        end
      end
      ST_RED_RD: state_nxt = ST_RED_CHK;
      ST_RED_CHK: begin
        if (sts.red_hit && !sts.red_limit) state_nxt = ST_RULE_RD;
        else if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_RULE_RD: state_nxt = ST_RULE_CHK;
      ST_RULE_CHK: begin
        if (!sts.rule_bad) state_nxt = ST_POP_RD;
        else if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_POP_RD: state_nxt = ST_GOTO_RD;
      ST_GOTO_RD: state_nxt = ST_GOTO_CHK;
      ST_GOTO_CHK: begin
        if (sts.out_free) state_nxt = sts.is_end ? ST_IDLE : ST_RED_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.act     = ACT_NONE;
    cmd.goto_lk = (state_r == ST_GOTO_RD) || (state_r == ST_GOTO_CHK);
    case (state_r)
      ST_CLEAR: cmd.act = ACT_CLEAR_STEP;
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_LOAD_TRANS, OP_LOAD_REDUCE, OP_LOAD_RULE: cmd.act = ACT_LOAD;
            OP_RESTART: cmd.act = ACT_RESTART;
            OP_TOKEN: if (!sts.failed) cmd.act = ACT_START_TOKEN;
            OP_END: if (!sts.failed) cmd.act = ACT_START_END;
            default: cmd.act = ACT_NONE;
          endcase
        end
      end
      ST_RED_CHK: begin
        if (sts.red_hit) begin
          if (!sts.red_limit) cmd.act = ACT_TAKE_RULE;
          else if (sts.out_free) cmd.act = ACT_ERR_LIMIT;
        end else if (sts.out_free) begin
          if (!sts.trans_hit) cmd.act = ACT_ERR_SYNTAX;
          else if (sts.stack_full) cmd.act = ACT_ERR_FULL;
          else cmd.act = ACT_SHIFT;
        end
      end
      ST_RULE_CHK: begin
        if (!sts.rule_bad) cmd.act = ACT_POP;
        else if (sts.out_free) cmd.act = ACT_ERR_RULE;
      end
      ST_GOTO_CHK: begin
        if (sts.out_free) cmd.act = ACT_PUSH_GOTO;
      end
      default: cmd.act = ACT_NONE;
    endcase
  end

endmodule

// ===== hdl/slr_dpath.sv =====
`include "slr_shift_reduce_parser_unit_macros.svh"

module slr_dpath
  import slr_pkg::*;
#(
  parameter int STATE_COUNT     = DEF_STATE_COUNT,
  parameter int SYMBOL_COUNT    = DEF_SYMBOL_COUNT,
  parameter int RULE_COUNT      = DEF_RULE_COUNT,
  parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
  parameter int REDUCE_LIMIT    = DEF_REDUCE_LIMIT,
  parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_table_state,
  input  logic [6:0]  in_symbol,
  input  logic [7:0]  in_next_state,
  input  logic [7:0]  in_rule_index,
  input  logic [6:0]  in_rule_lhs,
  input  logic [3:0]  in_rule_length,
  input  logic        in_entry_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_rule,
  output logic [6:0]  out_symbol_pushed,
  output logic [7:0]  out_new_state,
  output logic [15:0] out_position,
  output logic [8:0]  out_depth,
  output logic        out_last,
  input  dp_cmd_t     cmd,
  output dp_status_t  sts
);

  localparam int SW = $clog2(STATE_COUNT);
  localparam int YW = $clog2(SYMBOL_COUNT);
  localparam int AW = SW + YW;
  localparam int TDEPTH = 1 << AW;
  localparam int RW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int KW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [3:0] LEN_CAP =
    (MAX_RULE_LENGTH >= 15) ? 4'd15 : 4'(MAX_RULE_LENGTH);

  function automatic logic [AW-1:0] key_f(input logic [7:0] st, input logic [6:0] sy);
    logic [SW+7:0] sx;
    logic [YW+6:0] yx;
    sx = (SW + 8)'(st);
    yx = (YW + 7)'(sy);
    return {sx[SW-1:0], yx[YW-1:0]};
  endfunction

  function automatic logic in_range_f(input logic [7:0] st, input logic [6:0] sy);
    return (32'(st) < 32'(STATE_COUNT)) && (32'(sy) < 32'(SYMBOL_COUNT));
  endfunction

  // Parse registers.
  logic [7:0]    top_r;
  logic [PW-1:0] sp_r, newsp_r;
  logic [6:0]    sym_r, lhs_r;
  logic [7:0]    rule_r;
  logic [15:0]   count_r;
  logic [5:0]    red_cnt_r;
  logic          failed_r, end_r;
  logic [AW-1:0] clr_r;

  // Memory ports.
  logic          tbl_we, trans_we, red_we;
  logic [AW-1:0] tbl_waddr, trans_raddr, red_raddr;
  logic [8:0]    tbl_wdata_t, tbl_wdata_r, trans_wdata, red_wdata, trans_rdata, red_rdata;
  logic          rule_we;
  logic [RW-1:0] rule_waddr, rule_raddr;
  logic [10:0]   rule_wdata, rule_rdata;
  logic          stk_we;
  logic [KW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;

  logic          load_key_ok, ridx_ok;
  logic [RW+7:0] ridx_x, rule_x;
  logic [3:0]    len_sat, rule_len;
  logic [6:0]    rule_lhs;
  logic [7:0]    ent_rule, newtop, lk_state, push_state;
  logic [6:0]    lk_sym;
  logic          lk_ok;
  logic [PW+3:0] len_x, sp_x;
  logic [PW+8:0] depth_x;
  logic          emit;
  logic [PW-1:0] sp_nxt;
  logic [7:0]    top_nxt;

  // Table writes: the clearing pass or a load.
  assign load_key_ok = in_range_f(in_table_state, in_symbol);
  assign ridx_x      = (RW + 8)'(in_rule_index);
  assign ridx_ok     = 32'(in_rule_index) < 32'(RULE_COUNT);
  assign tbl_waddr   = (cmd.act == ACT_CLEAR_STEP) ? clr_r
                                                   : key_f(in_table_state, in_symbol);
  assign tbl_wdata_t = in_entry_valid ? {1'b1, in_next_state} : 9'd0;
  assign tbl_wdata_r = in_entry_valid ? {1'b1, in_rule_index} : 9'd0;
  assign tbl_we      = (cmd.act == ACT_CLEAR_STEP);
  assign trans_we    = tbl_we || (cmd.act == ACT_LOAD && in_op == OP_LOAD_TRANS && load_key_ok);
  assign red_we      = tbl_we || (cmd.act == ACT_LOAD && in_op == OP_LOAD_REDUCE &&
                                  load_key_ok && ridx_ok);
  assign trans_wdata = tbl_we ? 9'd0 : tbl_wdata_t;
  assign red_wdata   = tbl_we ? 9'd0 : tbl_wdata_r;

  // Rule table writes, length saturated.
  assign len_sat    = (in_rule_length > LEN_CAP) ? LEN_CAP : in_rule_length;
  assign rule_we    = (cmd.act == ACT_LOAD) && (in_op == OP_LOAD_RULE) && ridx_ok;
  assign rule_waddr = ridx_x[RW-1:0];
  assign rule_wdata = in_entry_valid ? {in_rule_lhs, len_sat} : 11'd0;
  assign rule_x     = (RW + 8)'(rule_r);
  assign rule_raddr = rule_x[RW-1:0];
  assign {rule_lhs, rule_len} = rule_rdata;

  // Lookups: token key, or goto key from the state left after a pop.
  assign newtop      = (newsp_r == PW'(1)) ? 8'd0 : stk_rdata;
  assign lk_state    = cmd.goto_lk ? newtop : top_r;
  assign lk_sym      = cmd.goto_lk ? lhs_r : sym_r;
  assign lk_ok       = in_range_f(lk_state, lk_sym);
  assign trans_raddr = key_f(lk_state, lk_sym);
  assign red_raddr   = key_f(top_r, sym_r);
  assign stk_raddr   = KW'(newsp_r - PW'(1));
  assign ent_rule    = (32'(red_rdata[7:0]) < 32'(RULE_COUNT)) ? red_rdata[7:0] : 8'd0;

  slr_ram #(.WIDTH(9), .DEPTH(TDEPTH)) u_trans (
    .clk(clk), .we(trans_we), .waddr(tbl_waddr), .wdata(trans_wdata),
    .raddr(trans_raddr), .rdata(trans_rdata)
  );

  slr_ram #(.WIDTH(9), .DEPTH(TDEPTH)) u_red (
    .clk(clk), .we(red_we), .waddr(tbl_waddr), .wdata(red_wdata),
    .raddr(red_raddr), .rdata(red_rdata)
  );

  slr_ram #(.WIDTH(11), .DEPTH(RULE_COUNT)) u_rule (
    .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
    .raddr(rule_raddr), .rdata(rule_rdata)
  );

  slr_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Stack pushes: a goto after a pop, or a shifted token.
  assign push_state = (trans_rdata[8] && lk_ok) ? trans_rdata[7:0] : 8'd0;
  assign stk_we     = (cmd.act == ACT_PUSH_GOTO) || (cmd.act == ACT_SHIFT);
  assign stk_waddr  = (cmd.act == ACT_PUSH_GOTO) ? KW'(newsp_r) : KW'(sp_r);
  assign stk_wdata  = push_state;

  // Next stack pointer and top state; restart goes back to the bottom entry.
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    if (cmd.act == ACT_RESTART) begin
      sp_nxt  = PW'(1);
      top_nxt = 8'd0;
    end else if (cmd.act == ACT_PUSH_GOTO) begin
      sp_nxt  = newsp_r + PW'(1);
      top_nxt = push_state;
    end else if (cmd.act == ACT_SHIFT) begin
      sp_nxt  = sp_r + PW'(1);
      top_nxt = push_state;
    end
  end

  // Status back to the controller.
  assign len_x = (PW + 4)'(rule_len);
  assign sp_x  = (PW + 4)'(sp_r);
  always_comb begin
    sts.failed     = failed_r;
    sts.clr_done   = (clr_r == {AW{1'b1}});
    sts.out_free   = !out_valid || out_ready;
    sts.red_hit    = red_rdata[8] && in_range_f(top_r, sym_r);
    sts.red_limit  = 32'(red_cnt_r) >= 32'(REDUCE_LIMIT);
    sts.trans_hit  = trans_rdata[8] && lk_ok;
    sts.stack_full = 32'(sp_r) >= 32'(STACK_DEPTH);
    sts.rule_bad   = (len_x >= sp_x) || ((rule_len == 4'd0) && sts.stack_full);
    sts.is_end     = end_r;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= 8'd0;
      sp_r      <= PW'(1);
      count_r   <= 16'd0;
      failed_r  <= 1'b0;
      end_r     <= 1'b0;
      red_cnt_r <= 6'd0;
      clr_r     <= '0;
    end else begin
      top_r <= top_nxt;
      sp_r  <= sp_nxt;
      case (cmd.act)
        ACT_CLEAR_STEP: clr_r <= clr_r + AW'(1);
        ACT_RESTART: begin
          count_r  <= 16'd0;
          failed_r <= 1'b0;
        end
        ACT_START_TOKEN: begin
          if (count_r != 16'hFFFF) count_r <= count_r + 16'd1;
          red_cnt_r <= 6'd0;
          end_r     <= 1'b0;
        end
        ACT_START_END: end_r <= 1'b1;
        ACT_PUSH_GOTO: begin
          red_cnt_r <= red_cnt_r + 6'd1;
          if (end_r) failed_r <= 1'b1;
        end
        ACT_ERR_SYNTAX, ACT_ERR_LIMIT, ACT_ERR_FULL, ACT_ERR_RULE: failed_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers of the current step.
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_START_TOKEN: sym_r <= in_symbol;
      ACT_START_END: rule_r <= 8'd0;
      ACT_TAKE_RULE: rule_r <= ent_rule;
      ACT_POP: begin
        newsp_r <= sp_r - PW'(rule_len);
        lhs_r   <= rule_lhs;
      end
      default: ;
    endcase
  end

  // Output beat register.
  assign emit = (cmd.act == ACT_PUSH_GOTO) || (cmd.act == ACT_SHIFT) ||
                (cmd.act == ACT_ERR_SYNTAX) || (cmd.act == ACT_ERR_LIMIT) ||
                (cmd.act == ACT_ERR_FULL) || (cmd.act == ACT_ERR_RULE);
  assign depth_x = (PW + 9)'(sp_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_new_state <= top_nxt;
      out_depth     <= depth_x[8:0];
      out_position  <= count_r;
      case (cmd.act)
        ACT_PUSH_GOTO: begin
          out_kind          <= end_r ? KIND_FINAL : KIND_REDUCE;
          out_rule          <= rule_r;
          out_symbol_pushed <= lhs_r;
          out_last          <= end_r;
        end
        ACT_SHIFT: begin
          out_kind          <= KIND_SHIFT;
          out_rule          <= 8'd0;
          out_symbol_pushed <= sym_r;
          out_last          <= 1'b1;
        end
        ACT_ERR_SYNTAX: begin
          out_kind          <= KIND_SYNTAX;
          out_rule          <= 8'd0;
          out_symbol_pushed <= sym_r;
          out_last          <= 1'b1;
        end
        ACT_ERR_LIMIT: begin
          out_kind          <= KIND_CAPACITY;
          out_rule          <= ent_rule;
          out_symbol_pushed <= sym_r;
          out_last          <= 1'b1;
        end
        ACT_ERR_RULE: begin
          out_kind          <= KIND_CAPACITY;
          out_rule          <= rule_r;
          out_symbol_pushed <= end_r ? 7'd0 : sym_r;
          out_last          <= 1'b1;
        end
        default: begin
          out_kind          <= KIND_CAPACITY;
          out_rule          <= 8'd0;
          out_symbol_pushed <= sym_r;
          out_last          <= 1'b1;
        end
      endcase
    end
  end

  // Checks.
  `ASSERT_IMPLIES(a_sp_range, clk, rst_n, 1'b1,
                  (sp_r != '0) && (32'(sp_r) <= 32'(STACK_DEPTH)))
  `ASSERT_IMPLIES(a_emit_free, clk, rst_n, emit, !out_valid || out_ready)
  `ASSERT_NEXT(a_err_stops, clk, rst_n,
               (cmd.act == ACT_ERR_SYNTAX) || (cmd.act == ACT_ERR_RULE), failed_r)

endmodule

// ===== hdl/slr_shift_reduce_parser_unit.sv =====
// Table-driven LR shift-reduce parser. Loads (ops 0-2), restart and unknown
// ops give no beat. A token reads the reduction table and then either shifts
// or runs a reduction, and repeats this until it shifts or stops; end applies
// rule 0 as one reduction, or stops when that reduction would leave the stack
// bounds. A token or end after the parse has stopped gives no beat. Each
// reduction is a chain of registered memory reads: reduction table,
// rule table, state stack, then the goto in the transition table. After
// reset the transition and reduction tables are cleared one entry a cycle,
// all 2^(clog2(STATE_COUNT)+clog2(SYMBOL_COUNT)) entries (32768 by default),
// during which no input beat is taken. Result beats wait in one output
// register; the parser stalls while it is full and not taken.
module slr_shift_reduce_parser_unit
  import slr_pkg::*;
#(
  parameter int STATE_COUNT     = DEF_STATE_COUNT,
  parameter int SYMBOL_COUNT    = DEF_SYMBOL_COUNT,
  parameter int RULE_COUNT      = DEF_RULE_COUNT,
  parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
  parameter int REDUCE_LIMIT    = DEF_REDUCE_LIMIT,
  parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_table_state,
  input  logic [6:0]  in_symbol,
  input  logic [7:0]  in_next_state,
  input  logic [7:0]  in_rule_index,
  input  logic [6:0]  in_rule_lhs,
  input  logic [3:0]  in_rule_length,
  input  logic        in_entry_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_rule,
  output logic [6:0]  out_symbol_pushed,
  output logic [7:0]  out_new_state,
  output logic [15:0] out_position,
  output logic [8:0]  out_depth,
  output logic        out_last
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  slr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_op),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  slr_dpath #(
    .STATE_COUNT(STATE_COUNT), .SYMBOL_COUNT(SYMBOL_COUNT),
    .RULE_COUNT(RULE_COUNT), .STACK_DEPTH(STACK_DEPTH),
    .REDUCE_LIMIT(REDUCE_LIMIT), .MAX_RULE_LENGTH(MAX_RULE_LENGTH)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_op(in_op), .in_table_state(in_table_state), .in_symbol(in_symbol),
    .in_next_state(in_next_state), .in_rule_index(in_rule_index),
    .in_rule_lhs(in_rule_lhs), .in_rule_length(in_rule_length),
    .in_entry_valid(in_entry_valid),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_rule(out_rule), .out_symbol_pushed(out_symbol_pushed),
    .out_new_state(out_new_state), .out_position(out_position),
    .out_depth(out_depth), .out_last(out_last),
    .cmd(cmd), .sts(sts)
  );

endmodule

// ===== sim/slr_parse_checker.sv =====
`timescale 1ns / 1ps

module slr_parse_checker
  import slr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_table_state,
  input  logic [6:0]  in_symbol,
  input  logic [7:0]  in_next_state,
  input  logic [7:0]  in_rule_index,
  input  logic [6:0]  in_rule_lhs,
  input  logic [3:0]  in_rule_length,
  input  logic        in_entry_valid,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_rule,
  input  logic [6:0]  out_symbol_pushed,
  input  logic [7:0]  out_new_state,
  input  logic [15:0] out_position,
  input  logic [8:0]  out_depth,
  input  logic        out_last,
  output int          pending,
  output int          fail_count,
  output int          beats_seen,
  output int          shifts_seen,
  output int          errors_seen
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  rule;
    logic [6:0]  sym;
    logic [7:0]  st;
    logic [15:0] pos;
    logic [8:0]  depth;
    logic        last;
  } parse_beat_t;

  // Shadow copy of the parser tables and stack.
  logic [8:0]  goto_mem [0:32767];
  logic [8:0]  reduce_mem [0:32767];
  logic [6:0]  lhs_mem [0:255];
  logic [3:0]  len_mem [0:255];
  logic [7:0]  stack_mem [0:255];
  int          sp;
  logic [15:0] tok_count;
  logic        stopped;
  parse_beat_t expected_beats[$];

  function automatic logic [7:0] top_state();
    return stack_mem[sp - 1];
  endfunction

  function automatic void push_beat(logic [2:0] kind, logic [7:0] rule, logic [6:0] sym);
    parse_beat_t b;
    b.kind = kind;
    b.rule = rule;
    b.sym = sym;
    b.st = top_state();
    b.pos = tok_count;
    b.depth = sp[8:0];
    b.last = 1'b0;
    expected_beats.push_back(b);
  endfunction

  // Pop the right side and push the goto of the left side.
  function automatic bit apply_rule(logic [7:0] r, output logic [6:0] lhs);
    int len;
    logic [8:0] g;
    len = int'(len_mem[r]);
    lhs = lhs_mem[r];
    if (len >= sp) return 1'b0;
    if (len == 0 && sp >= 256) return 1'b0;
    sp = sp - len;
    g = goto_mem[{top_state(), lhs}];
    stack_mem[sp] = g[8] ? g[7:0] : 8'd0;
    sp = sp + 1;
    return 1'b1;
  endfunction

  // Work out the beats caused by one accepted input item.
  function automatic void predict_parse(logic [2:0] op, logic [7:0] tst, logic [6:0] sym,
                                        logic [7:0] nst, logic [7:0] ridx, logic [6:0] rlhs,
                                        logic [3:0] rlen, logic ev);
    int before_n;
    int nred;
    logic [8:0] e;
    logic [6:0] lhs;
    before_n = expected_beats.size();
    case (op)
      OP_LOAD_TRANS: goto_mem[{tst, sym}] = ev ? {1'b1, nst} : 9'd0;
      OP_LOAD_REDUCE: reduce_mem[{tst, sym}] = ev ? {1'b1, ridx} : 9'd0;
      OP_LOAD_RULE: begin
        lhs_mem[ridx] = ev ? rlhs : 7'd0;
        len_mem[ridx] = ev ? rlen : 4'd0;
      end
      OP_RESTART: begin
        stack_mem[0] = 8'd0;
        sp = 1;
        tok_count = 16'd0;
        stopped = 1'b0;
      end
      OP_TOKEN: begin
        if (!stopped) begin
          if (tok_count != 16'hFFFF) tok_count = tok_count + 16'd1;
          nred = 0;
          // Reduce while a reduction matches the top state and the token.
          while (!stopped) begin
            e = reduce_mem[{top_state(), sym}];
            if (!e[8]) break;
            if (nred >= 63 || !apply_rule(e[7:0], lhs)) begin
              push_beat(KIND_CAPACITY, e[7:0], sym);
              stopped = 1'b1;
            end else begin
              push_beat(KIND_REDUCE, e[7:0], lhs);
              nred++;
            end
          end
          if (!stopped) begin
            e = goto_mem[{top_state(), sym}];
            if (!e[8]) begin
              push_beat(KIND_SYNTAX, 8'd0, sym);
              stopped = 1'b1;
            end else if (sp >= 256) begin
              push_beat(KIND_CAPACITY, 8'd0, sym);
              stopped = 1'b1;
            end else begin
              stack_mem[sp] = e[7:0];
              sp = sp + 1;
              push_beat(KIND_SHIFT, 8'd0, sym);
            end
          end
        end
      end
      OP_END: begin
        if (!stopped) begin
          if (apply_rule(8'd0, lhs)) push_beat(KIND_FINAL, 8'd0, lhs);
          else push_beat(KIND_CAPACITY, 8'd0, 7'd0);
          stopped = 1'b1;
        end
      end
      default: ;
    endcase
    // Mark the final beat of this item.
    if (expected_beats.size() > before_n)
      expected_beats[expected_beats.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    parse_beat_t want;
    parse_beat_t got;
    if (!rst_n) begin
      for (int i = 0; i < 32768; i++) begin
        goto_mem[i] = 9'd0;
        reduce_mem[i] = 9'd0;
      end
      for (int i = 0; i < 256; i++) begin
        lhs_mem[i] = 7'd0;
        len_mem[i] = 4'd0;
        stack_mem[i] = 8'd0;
      end
      sp = 1;
      tok_count = 16'd0;
      stopped = 1'b0;
      expected_beats.delete();
      fail_count = 0;
      beats_seen = 0;
      shifts_seen = 0;
      errors_seen = 0;
    end else begin
      if (in_valid && in_ready)
        predict_parse(in_op, in_table_state, in_symbol, in_next_state, in_rule_index,
                      in_rule_lhs, in_rule_length, in_entry_valid);
      // Compare each result beat with the oldest expected one.
      if (out_valid && out_ready) begin
        got = {out_kind, out_rule, out_symbol_pushed, out_new_state, out_position,
               out_depth, out_last};
        beats_seen++;
        if (out_kind == KIND_SHIFT) shifts_seen++;
        if (out_kind == KIND_SYNTAX || out_kind == KIND_CAPACITY) errors_seen++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected beat kind=%0d rule=%0d", $realtime, out_kind, out_rule);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp kind=%0d rule=%0d sym=%0d st=%0d pos=%0d ",
                        "depth=%0d last=%0d got kind=%0d rule=%0d sym=%0d st=%0d pos=%0d ",
                        "depth=%0d last=%0d"}, $realtime,
                       want.kind, want.rule, want.sym, want.st, want.pos, want.depth,
                       want.last, got.kind, got.rule, got.sym, got.st, got.pos,
                       got.depth, got.last);
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import slr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [7:0]  in_table_state;
  logic [6:0]  in_symbol;
  logic [7:0]  in_next_state;
  logic [7:0]  in_rule_index;
  logic [6:0]  in_rule_lhs;
  logic [3:0]  in_rule_length;
  logic        in_entry_valid;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_rule;
  logic [6:0]  out_symbol_pushed;
  logic [7:0]  out_new_state;
  logic [15:0] out_position;
  logic [8:0]  out_depth;
  logic        out_last;
  int          pending;
  int          fail_count;
  int          beats_seen;
  int          shifts_seen;
  int          errors_seen;

  bit          quiet;
  bit          hold_req;
  bit          rule_written [0:255];
  int          stall_cycles;
  int          items_sent;

  slr_shift_reduce_parser_unit uut (.*);

  slr_parse_checker checker_i (.*);

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 100000) begin
      $display("FAIL slr_shift_reduce_parser_unit");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int burst;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one beat and hold it until it is taken.
  task automatic send_beat(logic [2:0] op, logic [7:0] tst, logic [6:0] sym, logic [7:0] nst,
                           logic [7:0] ridx, logic [6:0] rlhs, logic [3:0] rlen, logic ev);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_table_state = tst;
    in_symbol = sym;
    in_next_state = nst;
    in_rule_index = ridx;
    in_rule_lhs = rlhs;
    in_rule_length = rlen;
    in_entry_valid = ev;
    in_valid = 1'b1;
    // Ready is stable between edges; the beat goes at the next rising edge.
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    if (op == OP_LOAD_RULE) rule_written[ridx] = 1'b1;
    items_sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [6:0] sym);
    send_beat(op, 8'($urandom()), sym, 8'($urandom()), 8'($urandom()), 7'($urandom()),
              4'($urandom()), 1'($urandom()));
  endtask

  task automatic load_goto(logic [7:0] st, logic [6:0] sym, logic [7:0] nst);
    send_beat(OP_LOAD_TRANS, st, sym, nst, 8'($urandom()), 7'($urandom()), 4'($urandom()),
              1'b1);
  endtask

  task automatic load_reduce(logic [7:0] st, logic [6:0] sym, logic [7:0] r, logic ev);
    send_beat(OP_LOAD_REDUCE, st, sym, 8'($urandom()), r, 7'($urandom()), 4'($urandom()), ev);
  endtask

  task automatic load_rule(logic [7:0] r, logic [6:0] lhs, logic [3:0] len, logic ev);
    send_beat(OP_LOAD_RULE, 8'($urandom()), 7'($urandom()), 8'($urandom()), r, lhs, len, ev);
  endtask

  // Random item, mostly tokens over a small dense grammar.
  task automatic send_random_item();
    int pick;
    logic [7:0] r;
    pick = $urandom_range(0, 99);
    r = 8'($urandom());
    if (!rule_written[r]) r = {4'd0, r[3:0]};
    if (pick < 50) send_op(OP_TOKEN, 7'($urandom_range(0, 7)));
    else if (pick < 53) send_op(OP_TOKEN, 7'($urandom()));
    else if (pick < 60) send_op(OP_END, 7'($urandom()));
    else if (pick < 70) send_op(OP_RESTART, 7'($urandom()));
    else if (pick < 80) begin
      if ($urandom_range(0, 9) == 0)
        load_goto(8'($urandom()), 7'($urandom()), 8'($urandom()));
      else
        load_goto(8'($urandom_range(0, 7)), 7'($urandom_range(0, 7)),
                  8'($urandom_range(0, 7)));
    end else if (pick < 90)
      load_reduce(8'($urandom_range(0, 7)), 7'($urandom_range(0, 7)), r,
                  $urandom_range(0, 3) != 0);
    else if (pick < 97) begin
      if ($urandom_range(0, 3) == 0)
        load_rule(8'($urandom()), 7'($urandom()), 4'($urandom()), 1'($urandom()));
      else
        load_rule(8'($urandom_range(0, 15)), 7'($urandom_range(0, 7)),
                  4'($urandom_range(0, 3)), 1'b1);
    end else send_op(($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6,
                     7'($urandom()));
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_RESTART;
    in_table_state = '0;
    in_symbol = '0;
    in_next_state = '0;
    in_rule_index = '0;
    in_rule_lhs = '0;
    in_rule_length = '0;
    in_entry_valid = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    for (int i = 0; i < 256; i++) rule_written[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Rule set; rule 0 is the one that end applies.
    for (int i = 0; i < 16; i++)
      load_rule(8'(i), 7'($urandom_range(1, 7)), 4'($urandom_range(0, 2)), 1'b1);
    load_rule(8'd0, 7'd1, 4'd1, 1'b1);
    load_rule(8'd1, 7'd2, 4'd0, 1'b1);
    load_rule(8'd2, 7'd3, 4'd2, 1'b1);
    load_rule(8'd3, 7'd4, 4'd3, 1'b1);
    load_rule(8'd255, 7'd127, 4'd15, 1'b1);
    load_rule(8'd5, 7'd9, 4'd1, 1'b0);

    // A short sentence: shift, shift, reduce with goto, shift, then end.
    load_goto(8'd0, 7'd10, 8'd1);
    load_goto(8'd1, 7'd11, 8'd2);
    load_reduce(8'd2, 7'd12, 8'd2, 1'b1);
    load_goto(8'd0, 7'd3, 8'd5);
    load_goto(8'd5, 7'd12, 8'd6);
    send_op(OP_TOKEN, 7'd10);
    send_op(OP_TOKEN, 7'd11);
    send_op(OP_TOKEN, 7'd12);
    send_op(OP_END, 7'd0);
    send_op(OP_TOKEN, 7'd10);
    send_op(OP_RESTART, 7'd0);
    // Underflow of the stack by a long right side.
    load_reduce(8'd0, 7'd13, 8'd3, 1'b1);
    send_op(OP_TOKEN, 7'd13);
    send_op(OP_RESTART, 7'd0);
    // Syntax error on a token with no transition.
    send_op(OP_TOKEN, 7'd127);
    send_op(OP_RESTART, 7'd0);
    // An empty rule that loops back to the same state runs into the limit.
    load_goto(8'd0, 7'd2, 8'd0);
    load_reduce(8'd0, 7'd14, 8'd1, 1'b1);
    send_op(OP_TOKEN, 7'd14);
    send_op(OP_RESTART, 7'd0);
    // End on an empty stack, unknown ops, and table extremes.
    send_op(OP_END, 7'd0);
    send_op(OP_UNUSED_6, 7'd0);
    send_op(OP_UNUSED_7, 7'd127);
    send_op(OP_RESTART, 7'd0);
    load_goto(8'd255, 7'd127, 8'd255);
    load_reduce(8'd255, 7'd127, 8'd255, 1'b0);

    // Overflow: after the first shift, each token pushes an empty-rule goto and then shifts.
    load_goto(8'd0, 7'd9, 8'd9);
    load_reduce(8'd9, 7'd9, 8'd1, 1'b1);
    load_goto(8'd9, 7'd2, 8'd10);
    load_goto(8'd10, 7'd9, 8'd9);
    for (int i = 0; i < 130; i++) send_op(OP_TOKEN, 7'd9);

    // The sender stops until every beat has arrived.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    send_op(OP_RESTART, 7'd0);

    // Random part, with one long hold-off on the result side.
    for (int i = 0; i < 100; i++) begin
      if (i == 30) hold_req = 1'b1;
      if (i == 85) quiet = 1'b1;
      send_random_item();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Run took %0d items and checked %0d result beats (%0d shifts, %0d errors).",
             items_sent, beats_seen, shifts_seen, errors_seen);
    if (fail_count == 0) begin
      $display("PASS slr_shift_reduce_parser_unit");
    end else begin
      $display("FAIL slr_shift_reduce_parser_unit");
    end
    $finish;
  end

endmodule
